FILE: src/fac_pkg.sv
// shared types, constants and helper functions for the fully associative cache
package fac_pkg;

    localparam int LINES      = 64;
    localparam int LINE_W     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WORDS      = 4;
    localparam int SEL_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int DATA_W     = 32;
    localparam int TAG_W      = ADDR_W - SEL_W;
    localparam int SLOT_W     = 6;
    localparam int LFSR_W     = 16;
    localparam int VIC_W      = LFSR_W + LINE_W;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_FILL  = 2'd1,
        OP_INVAL = 2'd2,
        OP_WRITE = 2'd3
    } op_e;

    typedef struct packed {
        op_e               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] line_word0;
        logic [DATA_W-1:0] line_word1;
        logic [DATA_W-1:0] line_word2;
        logic [DATA_W-1:0] line_word3;
    } cache_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_word;
        logic              miss;
        logic [SLOT_W-1:0] slot;
    } cache_out_t;

    // lookup token that walks the cell row
    typedef struct packed {
        logic              active;
        logic [TAG_W-1:0]  tag;
        logic              hit;
        logic [LINE_W-1:0] hit_idx;
        logic              free;
        logic [LINE_W-1:0] free_idx;
    } search_t;

    // tag/valid update broadcast to the cells
    typedef struct packed {
        logic              fill;
        logic              inval;
        logic [LINE_W-1:0] idx;
        logic [TAG_W-1:0]  tag;
    } cell_wr_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [LINE_W-1:0] idx);
        logic [LINE_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    // fibonacci lfsr, taps 16 14 13 11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[LFSR_W-1:1]};
    endfunction

endpackage

FILE: src/fac_cell.sv
// one cache line cell: holds tag and valid, checks the passing lookup token
module fac_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fac_pkg::LINE_W-1:0]  my_idx,
    input  fac_pkg::search_t            search_in,
    output fac_pkg::search_t            search_out,
    input  fac_pkg::cell_wr_t           wr
);
    import fac_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;
    search_t           out_reg;
    search_t           out_next;
    logic              wr_hit;

    assign wr_hit = (wr.idx == my_idx);

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (wr.fill && wr_hit)
        begin
            valid_next = 1'b1;
            tag_next   = wr.tag;
        end
        else if (wr.inval && wr_hit)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_next = search_in;
        if (search_in.active)
        begin
            // lowest index wins: only claim if no earlier cell did
            if (!search_in.hit && valid_reg && (tag_reg == search_in.tag))
            begin
                out_next.hit     = 1'b1;
                out_next.hit_idx = my_idx;
            end
            if (!search_in.free && !valid_reg)
            begin
                out_next.free     = 1'b1;
                out_next.free_idx = my_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign search_out = out_reg;

endmodule

FILE: src/fac_chain.sv
// row of line cells with the lookup token passed from cell to cell
module fac_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fac_pkg::search_t     head,
    output fac_pkg::search_t     tail,
    input  fac_pkg::cell_wr_t    wr
);
    import fac_pkg::*;

    search_t link [LINES+1];

    assign link[0] = head;

    for (genvar i = 0; i < LINES; i++)
    begin : g_cell
        fac_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .my_idx     (LINE_W'(i)),
            .search_in  (link[i]),
            .search_out (link[i+1]),
            .wr         (wr)
        );
    end

    assign tail = link[LINES];

endmodule

FILE: src/fully_associative_cache_top.sv
// fully associative cache: cell row for lookup, banked line data memory, control
// steps: the accepted request enters the head register, its lookup token is registered in
// every cell of the row, the row result is captured and the act state registers the result
// strobe; a read hit passes through a further read state before its strobe; transactions do not overlap:
// start is taken again from the cycle of the strobe
// reset: all lines invalid at once, replacement lfsr at 0xACE1; results cannot be stalled
module fully_associative_cache_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fac_pkg::cache_in_t   in_item,
    output logic                 done,
    output fac_pkg::cache_out_t  result
);
    import fac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_ACT    = 4'b0100,
        S_READ   = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    cache_in_t          item_reg;
    search_t            head_reg;
    search_t            head_next;
    search_t            res_reg;
    search_t            chain_out;
    cell_wr_t           cell_wr;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [LFSR_W-1:0]  lfsr_next;
    logic               done_reg;
    logic               done_next;
    cache_out_t         result_reg;
    cache_out_t         result_next;

    logic [DATA_W-1:0]  data_mem    [WORDS][LINES];
    logic [DATA_W-1:0]  rd_data_reg [WORDS];
    logic [DATA_W-1:0]  mem_wdata   [WORDS];
    logic [WORDS-1:0]   mem_we;
    logic [LINE_W-1:0]  mem_wr_idx;
    logic               rd_en;
    logic [LINE_W-1:0]  rd_idx;

    logic               accept;
    logic [SEL_W-1:0]   sel;
    logic [VIC_W-1:0]   vic_prod;
    logic [LINE_W-1:0]  victim;
    logic [LINE_W-1:0]  fill_idx;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign sel    = item_reg.addr[SEL_W-1:0];

    // victim = (lfsr * LINES) >> 16, always below LINES
    assign vic_prod = VIC_W'(lfsr_reg) * VIC_W'(LINES);
    assign victim   = vic_prod[LFSR_W +: LINE_W];
    assign fill_idx = res_reg.free ? res_reg.free_idx : victim;

    fac_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head_reg),
        .tail  (chain_out),
        .wr    (cell_wr)
    );

    always_comb
    begin
        state_next  = state_reg;
        head_next   = '0;
        done_next   = 1'b0;
        result_next = result_reg;
        lfsr_next   = lfsr_reg;
        cell_wr     = '0;
        mem_we      = '0;
        mem_wr_idx  = res_reg.hit_idx;
        rd_en       = 1'b0;
        rd_idx      = res_reg.hit_idx;
        for (int k = 0; k < WORDS; k++)
        begin
            mem_wdata[k] = item_reg.line_word0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    head_next.active = 1'b1;
                    head_next.tag    = in_item.addr[ADDR_W-1:SEL_W];
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (chain_out.active)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                done_next   = 1'b1;
                state_next  = S_IDLE;
                result_next = '0;
                unique case (item_reg.op)
                    OP_READ:
                    begin
                        if (res_reg.hit)
                        begin
                            rd_en      = 1'b1;
                            done_next  = 1'b0;
                            state_next = S_READ;
                        end
                        else
                        begin
                            result_next.miss = 1'b1;
                        end
                    end
                    OP_FILL:
                    begin
                        if (!res_reg.free)
                        begin
                            lfsr_next = lfsr_step(lfsr_reg);
                        end
                        cell_wr.fill     = 1'b1;
                        cell_wr.idx      = fill_idx;
                        cell_wr.tag      = item_reg.addr[ADDR_W-1:SEL_W];
                        mem_we           = '1;
                        mem_wr_idx       = fill_idx;
                        mem_wdata[0]     = item_reg.line_word0;
                        mem_wdata[1]     = item_reg.line_word1;
                        mem_wdata[2]     = item_reg.line_word2;
                        mem_wdata[3]     = item_reg.line_word3;
                        result_next.slot = to_slot(fill_idx);
                    end
                    OP_INVAL:
                    begin
                        if (res_reg.hit)
                        begin
                            cell_wr.inval    = 1'b1;
                            cell_wr.idx      = res_reg.hit_idx;
                            result_next.slot = to_slot(res_reg.hit_idx);
                        end
                    end
                    OP_WRITE:
                    begin
                        if (res_reg.hit)
                        begin
                            mem_we[sel]      = 1'b1;
                            result_next.slot = to_slot(res_reg.hit_idx);
                        end
                        else
                        begin
                            result_next.miss = 1'b1;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                done_next             = 1'b1;
                state_next            = S_IDLE;
                result_next.read_word = rd_data_reg[sel];
                result_next.miss      = 1'b0;
                result_next.slot      = to_slot(res_reg.hit_idx);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            done_reg  <= 1'b0;
            lfsr_reg  <= LFSR_SEED;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (state_reg == S_SEARCH && chain_out.active)
        begin
            res_reg <= chain_out;
        end
        result_reg <= result_next;
    end

    // one bank per word of the line
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WORDS; k++)
        begin
            if (mem_we[k])
            begin
                data_mem[k][mem_wr_idx] <= mem_wdata[k];
            end
            if (rd_en)
            begin
                rd_data_reg[k] <= data_mem[k][rd_idx];
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepting a transaction");

    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active |-> (state_reg == S_SEARCH))
        else $error("lookup token left the cell row outside the search phase");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.miss) |-> (result.slot == '0 && result.read_word == '0))
        else $error("miss result carries a slot or data");
`endif

endmodule

FILE: tb/sv/fac_checker.sv
// checker for the fully associative cache: shadow cache model and result compare
module fac_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  fac_pkg::cache_in_t   in_item,
    input  logic                 done,
    input  fac_pkg::cache_out_t  result,
    output int                   fail_count,
    output int                   open_count
);
    import fac_pkg::*;

    logic [TAG_W-1:0]  shadow_tag   [LINES];
    bit                shadow_valid [LINES];
    logic [DATA_W-1:0] shadow_word  [LINES*WORDS];
    logic [LFSR_W-1:0] shadow_lfsr;

    cache_out_t awaited[$];
    int         mismatches = 0;

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // applies one transaction to the shadow cache and returns what the block should answer
    function automatic cache_out_t apply_access(input cache_in_t t);
        cache_out_t        r;
        logic [TAG_W-1:0]  tag;
        logic [SEL_W-1:0]  sel;
        int                hit;
        int                line;
        logic              fb;
        r   = '0;
        tag = t.addr[ADDR_W-1:SEL_W];
        sel = t.addr[SEL_W-1:0];
        hit = -1;
        // lowest matching valid line wins
        for (int i = 0; i < LINES; i++)
            if (hit < 0 && shadow_valid[i] && shadow_tag[i] == tag)
                hit = i;
        case (t.op)
            OP_READ:
            begin
                if (hit < 0)
                    r.miss = 1'b1;
                else
                begin
                    r.read_word = shadow_word[hit*WORDS + sel];
                    r.slot      = hit[SLOT_W-1:0];
                end
            end
            OP_FILL:
            begin
                line = -1;
                for (int i = 0; i < LINES; i++)
                    if (line < 0 && !shadow_valid[i])
                        line = i;
                if (line < 0)
                begin
                    // no free line: scale the lfsr onto the line range, then step it
                    line        = (int'(shadow_lfsr) * LINES) >> LFSR_W;
                    fb          = shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3]
                                  ^ shadow_lfsr[5];
                    shadow_lfsr = {fb, shadow_lfsr[LFSR_W-1:1]};
                end
                shadow_tag[line]            = tag;
                shadow_valid[line]          = 1'b1;
                shadow_word[line*WORDS + 0] = t.line_word0;
                shadow_word[line*WORDS + 1] = t.line_word1;
                shadow_word[line*WORDS + 2] = t.line_word2;
                shadow_word[line*WORDS + 3] = t.line_word3;
                r.slot                      = line[SLOT_W-1:0];
            end
            OP_INVAL:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    r.slot            = hit[SLOT_W-1:0];
                end
            end
            default:
            begin
                if (hit < 0)
                    r.miss = 1'b1;
                else
                begin
                    shadow_word[hit*WORDS + sel] = t.line_word0;
                    r.slot                       = hit[SLOT_W-1:0];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_tag[i]   = '0;
            end
            for (int i = 0; i < LINES*WORDS; i++)
                shadow_word[i] = '0;
            shadow_lfsr = LFSR_SEED;
            awaited.delete();
            open_count <= 0;
        end
        else
        begin
            // compare before taking a new transaction: a start on the strobe cycle is later
            if (done)
            begin
                if (awaited.size() == 0)
                    flag_mismatch("result with no transaction pending", result.read_word, '0);
                else
                begin
                    want = awaited.pop_front();
                    if (result.read_word !== want.read_word)
                        flag_mismatch("read_word", result.read_word, want.read_word);
                    if (result.miss !== want.miss)
                        flag_mismatch("miss", DATA_W'(result.miss), DATA_W'(want.miss));
                    if (result.slot !== want.slot)
                        flag_mismatch("slot", DATA_W'(result.slot), DATA_W'(want.slot));
                end
            end
            if (start && !busy)
                awaited.push_back(apply_access(in_item));
            open_count <= awaited.size();
        end
        fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/fully_associative_cache_top_tb.sv
// testbench top for the fully associative cache: stimulus, block, checker and verdict
module fully_associative_cache_top_tb;
    import fac_pkg::*;

    localparam int POOL = 96;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       start   = 1'b0;
    cache_in_t  in_item = '0;
    logic       busy;
    logic       done;
    cache_out_t result;
    int         fail_count;
    int         open_count;
    bit         quiet   = 1'b0;

    logic [TAG_W-1:0] tag_pool [POOL];

    always #5 clk = ~clk;

    fully_associative_cache_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    fac_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_item    (in_item),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial
    begin
        #(4_000_000);
        $display("fully_associative_cache_top regression: fail");
        $finish;
    end

    function automatic cache_in_t make_item(input op_e op, input logic [ADDR_W-1:0] a,
                                            input logic [DATA_W-1:0] w0,
                                            input logic [DATA_W-1:0] w1,
                                            input logic [DATA_W-1:0] w2,
                                            input logic [DATA_W-1:0] w3);
        cache_in_t t;
        t.op         = op;
        t.addr       = a;
        t.line_word0 = w0;
        t.line_word1 = w1;
        t.line_word2 = w2;
        t.line_word3 = w3;
        return t;
    endfunction

    // drives one transaction and returns at the edge that accepts it
    task automatic send_item(input cache_in_t item);
        int gap;
        bit hold_off;
        gap      = quiet ? 0 : $urandom_range(0, 3);
        hold_off = !quiet && ($urandom_range(0, 1) == 1);
        if (gap != 0 || hold_off)
        begin
            start <= 1'b0;
            // let the block finish first so the gap lands after the strobe
            if (hold_off)
            begin
                do
                    @(posedge clk);
                while (busy);
            end
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int                r;
        int                fill_pct;
        int                inval_pct;
        op_e               op;
        logic [ADDR_W-1:0] a;
        logic [SEL_W-1:0]  sel;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            tag_pool[i] = TAG_W'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache: every lookup misses
        send_item(make_item(OP_READ,  32'h0000_0000, '0, '0, '0, '0));
        send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 32'hDEAD_BEEF, '0, '0, '0));
        send_item(make_item(OP_INVAL, 32'h0000_0000, '0, '0, '0, '0));
        // lowest and highest tag
        send_item(make_item(OP_FILL,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                            32'hA5A5_A5A5, 32'h5A5A_5A5A));
        send_item(make_item(OP_FILL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                            32'h1234_5678, 32'h8765_4321));
        for (int s = 0; s < WORDS; s++)
            send_item(make_item(OP_READ, ADDR_W'(s), '0, '0, '0, '0));
        send_item(make_item(OP_READ,  32'hFFFF_FFFF, '0, '0, '0, '0));
        send_item(make_item(OP_READ,  32'hFFFF_FFFC, '0, '0, '0, '0));
        send_item(make_item(OP_WRITE, 32'h0000_0002, 32'hFFFF_FFFF, '0, '0, '0));
        send_item(make_item(OP_READ,  32'h0000_0002, '0, '0, '0, '0));
        send_item(make_item(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0, '0));
        send_item(make_item(OP_READ,  32'hFFFF_FFFF, '0, '0, '0, '0));
        // same tag filled twice: the lower line serves lookups until invalidated
        send_item(make_item(OP_FILL,  32'h0000_0001, 32'h1111_1111, 32'h2222_2222,
                            32'h3333_3333, 32'h4444_4444));
        send_item(make_item(OP_READ,  32'h0000_0001, '0, '0, '0, '0));
        send_item(make_item(OP_INVAL, 32'h0000_0003, '0, '0, '0, '0));
        send_item(make_item(OP_READ,  32'h0000_0001, '0, '0, '0, '0));
        send_item(make_item(OP_INVAL, 32'h0000_0000, '0, '0, '0, '0));
        send_item(make_item(OP_INVAL, 32'h0000_0000, '0, '0, '0, '0));
        send_item(make_item(OP_READ,  32'h0000_0000, '0, '0, '0, '0));
        send_item(make_item(OP_WRITE, 32'hFFFF_FFFE, 32'hCAFE_F00D, '0, '0, '0));
        send_item(make_item(OP_INVAL, 32'hFFFF_FFFF, '0, '0, '0, '0));

        // random part over a tag pool larger than the cache, so it fills and replaces
        fill_pct  = 40;
        inval_pct = 5;
        for (int n = 0; n < 1100; n++)
        begin
            if (n % 100 == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    fill_pct  = 40;
                    inval_pct = 5;
                end
                else
                begin
                    fill_pct  = 25;
                    inval_pct = 20;
                end
                quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < fill_pct)
                op = OP_FILL;
            else if (r < fill_pct + inval_pct)
                op = OP_INVAL;
            else if (r < fill_pct + inval_pct + 20)
                op = OP_WRITE;
            else
                op = OP_READ;
            sel = SEL_W'($urandom_range(0, WORDS - 1));
            if ($urandom_range(0, 9) == 0)
                a = $urandom;
            else
                a = {tag_pool[$urandom_range(0, POOL - 1)], sel};
            send_item(make_item(op, a, $urandom, $urandom, $urandom, $urandom));
        end
        start <= 1'b0;

        do
            @(posedge clk);
        while (open_count != 0);
        // room for a stray strobe after the last expected one
        repeat (80) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
            $display("fully_associative_cache_top regression: pass");
        else
            $display("fully_associative_cache_top regression: fail");
        $finish;
    end

endmodule
